// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros for the RTL file that checks its own logic.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge out of reset.
`define ASSERT_HOLDS(lbl, clk_sig, rst_sig, cond) \
  lbl: assert property (@(posedge clk_sig) disable iff (rst_sig) (cond)) \
    else $error("assertion failed: condition does not hold");

// Check that a trigger is followed by a condition on the next edge.
`define ASSERT_NEXT(lbl, clk_sig, rst_sig, trig, cond) \
  lbl: assert property (@(posedge clk_sig) disable iff (rst_sig) (trig) |=> (cond)) \
    else $error("assertion failed: expected condition on next cycle");

`endif

// ===== rtl/dspr_pkg.sv =====
// ----------------------------------------------------------------------------
// dspr_pkg
// Types, register codes and the nibble decode step of the subpicture decoder.
// ----------------------------------------------------------------------------
package dspr_pkg;

  localparam int MAX_LINE_WIDTH = 4096;
  localparam int WIDTH_W        = 13;
  localparam int LINES_W        = 12;
  localparam int LINE_IDX_W     = 11;
  localparam int COLOR_W        = 32;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 32;

  localparam logic [WIDTH_W-1:0] MAX_WIDTH_VAL   = WIDTH_W'(MAX_LINE_WIDTH);
  localparam logic [WIDTH_W-1:0] RESET_WIDTH     = 13'd720;
  localparam logic [LINES_W-1:0] RESET_LINES     = 12'd288;

  // Code completion thresholds for one, two and three nibbles
  localparam logic [15:0] CODE_MIN_ONE   = 16'h0004;
  localparam logic [15:0] CODE_MIN_TWO   = 16'h0010;
  localparam logic [15:0] CODE_MIN_THREE = 16'h0040;
  localparam logic [1:0]  COLOR_MASK     = 2'h3;
  localparam logic [3:0]  NIBBLE_MASK    = 4'hf;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LINE_WIDTH  = 3'd0,
    REG_FIELD_LINES = 3'd1,
    REG_COLOR_ZERO  = 3'd2,
    REG_COLOR_ONE   = 3'd3,
    REG_COLOR_TWO   = 3'd4,
    REG_COLOR_THREE = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [WIDTH_W-1:0]         line_width;   // already clamped to 1..MAX
    logic [LINES_W-1:0]         field_lines;
    logic [3:0][COLOR_W-1:0]    colors;
  } cfg_t;

  typedef struct packed {
    logic [11:0]        partial_code;
    logic [1:0]         nibbles_held;
    logic [WIDTH_W-1:0] column;
    logic [LINES_W-1:0] line_count;
    logic               field_done;
  } dec_state_t;

  typedef struct packed {
    dec_state_t            st;
    logic                  valid;
    logic [1:0]            color;
    logic [WIDTH_W-1:0]    length;
    logic                  eol;
    logic [LINE_IDX_W-1:0] line_index;
  } step_t;

  typedef struct packed {
    logic [COLOR_W-1:0]    run_color;
    logic [WIDTH_W-1:0]    run_length;
    logic                  end_of_line;
    logic [LINE_IDX_W-1:0] line_index;
    logic                  last;
  } run_t;

  typedef struct packed {
    logic [1:0] count;
    run_t       run_a;
    run_t       run_b;
  } run_pair_t;

  // Feed one nibble into the code collector and line tracker
  function automatic step_t nibble_step(dec_state_t s, logic [3:0] nib,
                                        logic [WIDTH_W-1:0] width,
                                        logic [LINES_W-1:0] lines);
    logic [15:0]        v;
    logic [WIDTH_W-1:0] remain;
    logic [13:0]        len;
    logic               complete;
    logic [LINES_W-1:0] lc_next;
    step_t              r;
    v      = {s.partial_code, nib};
    remain = (s.column < width) ? (width - s.column) : WIDTH_W'(1);
    case (s.nibbles_held)
      2'd0:    complete = (v >= CODE_MIN_ONE);
      2'd1:    complete = (v >= CODE_MIN_TWO);
      2'd2:    complete = (v >= CODE_MIN_THREE);
      default: complete = 1'b1;
    endcase
    len = v[15:2];
    if (len == 14'd0 || len > {1'b0, remain}) begin
      len = {1'b0, remain};
    end
    r            = '0;
    r.st         = s;
    r.color      = v[1:0] & COLOR_MASK;
    r.length     = len[WIDTH_W-1:0];
    r.line_index = s.line_count[LINE_IDX_W-1:0];
    lc_next      = s.line_count + LINES_W'(1);
    if (!complete) begin
      r.st.partial_code = v[11:0];
      r.st.nibbles_held = s.nibbles_held + 2'd1;
    end else begin
      r.valid           = 1'b1;
      r.st.partial_code = '0;
      r.st.nibbles_held = '0;
      if (len[WIDTH_W-1:0] == remain) begin
        r.eol           = 1'b1;
        r.st.column     = '0;
        r.st.line_count = lc_next;
        if (lc_next >= lines) begin
          r.st.field_done = 1'b1;
        end
      end else begin
        r.st.column = s.column + len[WIDTH_W-1:0];
      end
    end
    return r;
  endfunction

endpackage

// ===== rtl/dspr_in_if.sv =====
// ----------------------------------------------------------------------------
// dspr_in_if
// Byte channel carrying encoded field data into the decoder.
// ----------------------------------------------------------------------------
interface dspr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       field_start;

  modport source (output valid, output data_byte, output field_start, input ready);
  modport sink   (input valid, input data_byte, input field_start, output ready);
endinterface

// ===== rtl/dspr_out_if.sv =====
// ----------------------------------------------------------------------------
// dspr_out_if
// Run channel carrying decoded color runs out of the decoder.
// ----------------------------------------------------------------------------
interface dspr_out_if import dspr_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [COLOR_W-1:0]    run_color;
  logic [WIDTH_W-1:0]    run_length;
  logic                  end_of_line;
  logic [LINE_IDX_W-1:0] line_index;
  logic                  last;

  modport source (output valid, output run_color, output run_length,
                  output end_of_line, output line_index, output last, input ready);
  modport sink   (input valid, input run_color, input run_length,
                  input end_of_line, input line_index, input last, output ready);
endinterface

// ===== rtl/dspr_cfg_if.sv =====
// ----------------------------------------------------------------------------
// dspr_cfg_if
// Register write channel: register index plus write data.
// ----------------------------------------------------------------------------
interface dspr_cfg_if import dspr_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/dspr_cfg.sv =====
// ----------------------------------------------------------------------------
// dspr_cfg
// Configuration registers; line width is stored already clamped.
// ----------------------------------------------------------------------------
module dspr_cfg import dspr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  dspr_cfg_if.sink   cfg,
  output cfg_t       regs
);

  logic [WIDTH_W-1:0] width_in;
  logic [WIDTH_W-1:0] width_clamped;

  assign cfg.ready = 1'b1;

  // Clamp width to 1..MAX_LINE_WIDTH
  always_comb begin
    width_in = cfg.data[WIDTH_W-1:0];
    if (width_in == '0) begin
      width_clamped = WIDTH_W'(1);
    end else if (width_in > MAX_WIDTH_VAL) begin
      width_clamped = MAX_WIDTH_VAL;
    end else begin
      width_clamped = width_in;
    end
  end

  // Write the addressed register; ignore indexes past the list
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.line_width  <= RESET_WIDTH;
      regs.field_lines <= RESET_LINES;
      regs.colors      <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_LINE_WIDTH:  regs.line_width  <= width_clamped;
        REG_FIELD_LINES: regs.field_lines <= cfg.data[LINES_W-1:0];
        REG_COLOR_ZERO:  regs.colors[0]   <= cfg.data[COLOR_W-1:0];
        REG_COLOR_ONE:   regs.colors[1]   <= cfg.data[COLOR_W-1:0];
        REG_COLOR_TWO:   regs.colors[2]   <= cfg.data[COLOR_W-1:0];
        REG_COLOR_THREE: regs.colors[3]   <= cfg.data[COLOR_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/dspr_decode.sv =====
// ----------------------------------------------------------------------------
// dspr_decode
// Decodes both nibbles of an accepted byte into up to two runs.
// ----------------------------------------------------------------------------
module dspr_decode import dspr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  dspr_in_if.sink    byte_in,
  input  cfg_t       regs,
  input  logic       can_take,
  output logic       load,
  output run_pair_t  pair
);

  dec_state_t state;
  dec_state_t state_next;
  dec_state_t start_st;
  step_t      hi;
  step_t      lo;
  run_t       run_hi;
  run_t       run_lo;

  assign byte_in.ready = can_take;
  assign load          = byte_in.valid & can_take;

  // Decode high nibble, then low nibble unless the line already ended
  always_comb begin
    start_st = byte_in.field_start ? dec_state_t'('0) : state;
    hi = nibble_step(start_st, byte_in.data_byte[7:4], regs.line_width, regs.field_lines);
    lo = nibble_step(hi.st, byte_in.data_byte[3:0] & NIBBLE_MASK, regs.line_width,
                     regs.field_lines);

    run_hi.run_color   = regs.colors[hi.color];
    run_hi.run_length  = hi.length;
    run_hi.end_of_line = hi.eol;
    run_hi.line_index  = hi.line_index;
    run_hi.last        = 1'b0;
    run_lo.run_color   = regs.colors[lo.color];
    run_lo.run_length  = lo.length;
    run_lo.end_of_line = lo.eol;
    run_lo.line_index  = lo.line_index;
    run_lo.last        = 1'b1;

    pair       = '0;
    state_next = start_st;
    if (!start_st.field_done) begin
      if (hi.valid && hi.eol) begin
        // drop the low nibble so the next line starts on a byte
        pair.count       = 2'd1;
        pair.run_a       = run_hi;
        pair.run_a.last  = 1'b1;
        state_next       = hi.st;
      end else begin
        state_next = lo.st;
        if (hi.valid && lo.valid) begin
          pair.count = 2'd2;
          pair.run_a = run_hi;
          pair.run_b = run_lo;
        end else if (hi.valid) begin
          pair.count      = 2'd1;
          pair.run_a      = run_hi;
          pair.run_a.last = 1'b1;
        end else if (lo.valid) begin
          pair.count = 2'd1;
          pair.run_a = run_lo;
        end
      end
    end
  end

  // Advance decode state on each accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (load) begin
      state <= state_next;
    end
  end

endmodule

// ===== rtl/dspr_outbuf.sv =====
// ----------------------------------------------------------------------------
// dspr_outbuf
// Two-entry result register that presents a byte's runs one word at a time.
// ----------------------------------------------------------------------------
module dspr_outbuf import dspr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       load,
  input  run_pair_t  pair,
  output logic       can_take,
  dspr_out_if.source run_out
);

  run_t       slot_a;
  run_t       slot_b;
  logic [1:0] count;
  logic       fire;

  assign fire     = run_out.valid & run_out.ready;
  assign can_take = (count == 2'd0) || (count == 2'd1 && run_out.ready);

  assign run_out.valid       = (count != 2'd0);
  assign run_out.run_color   = slot_a.run_color;
  assign run_out.run_length  = slot_a.run_length;
  assign run_out.end_of_line = slot_a.end_of_line;
  assign run_out.line_index  = slot_a.line_index;
  assign run_out.last        = slot_a.last;

  // Hold count of pending runs
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (load) begin
      count <= pair.count;
    end else if (fire) begin
      count <= count - 2'd1;
    end
  end

  // Load new runs, or shift the second run forward once the first is taken
  always_ff @(posedge clk) begin
    if (load) begin
      slot_a <= pair.run_a;
      slot_b <= pair.run_b;
    end else if (fire) begin
      slot_a <= slot_b;
    end
  end

endmodule

// ===== rtl/dvd_subpicture_rle_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// dvd_subpicture_rle_decoder_unit
// Run-length decoder for one field of DVD subpicture data.
// ----------------------------------------------------------------------------
// Usage:
//   byte_in carries one encoded byte per word, high nibble decoded first;
//   field_start on a word clears line and code state before that byte.
//   run_out carries runs as pixel word, length, end-of-line flag, line index
//   and a last flag on the final run a byte produced.
//   cfg writes line width, field line count and the four pixel words; it is
//   always ready; the user must write it only while the decoder is idle (not enforced).
// Timing:
//   Runs of a byte appear in the cycle after it is accepted. A byte that yields
//   zero or one run is taken every cycle while run_out is ready; a byte that
//   yields two runs holds byte_in off until the first of them has been taken.
// Reset:
//   rst clears decode state, empties the output register and loads default
//   configuration (width 720, 288 lines, all pixel words zero).
// Stall:
//   While run_out is held off with a run pending, byte_in.ready stays low.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dvd_subpicture_rle_decoder_unit import dspr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  dspr_in_if.sink    byte_in,
  dspr_out_if.source run_out,
  dspr_cfg_if.sink   cfg
);

  cfg_t      regs;
  run_pair_t pair;
  logic      load;
  logic      can_take;

  dspr_cfg u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  dspr_decode u_decode (
    .clk      (clk),
    .rst      (rst),
    .byte_in  (byte_in),
    .regs     (regs),
    .can_take (can_take),
    .load     (load),
    .pair     (pair)
  );

  dspr_outbuf u_outbuf (
    .clk      (clk),
    .rst      (rst),
    .load     (load),
    .pair     (pair),
    .can_take (can_take),
    .run_out  (run_out)
  );

  // Self checks
  `ASSERT_HOLDS(a_len_nonzero, clk, rst, !run_out.valid || run_out.run_length != '0)
  `ASSERT_HOLDS(a_stall_blocks, clk, rst, !(run_out.valid && !run_out.ready) || !can_take)
  `ASSERT_NEXT(a_pair_shown, clk, rst, load && pair.count == 2'd2,
               run_out.valid && !run_out.last)

endmodule

// ===== tb/rle_run_checker.sv =====
// ----------------------------------------------------------------------------
// rle_run_checker
// Watches the byte, run and register channels of the subpicture decoder,
// decodes every accepted byte on its own and compares each run word that
// leaves the block, field by field, against the oldest predicted run.
// ----------------------------------------------------------------------------
module rle_run_checker import dspr_pkg::*; (
  input  logic clk,
  input  logic rst,
  dspr_in_if   byte_in,
  dspr_out_if  run_out,
  dspr_cfg_if  cfg,
  output int   failures,
  output int   pending,
  output int   checked
);

  localparam int REPORT_LIMIT = 10;

  // Register copy, width kept raw and clamped where it is used
  logic [WIDTH_W-1:0] width_reg;
  logic [LINES_W-1:0] lines_reg;
  logic [COLOR_W-1:0] pixel_word [4];

  // Decode state
  logic [11:0]        code_bits;
  logic [1:0]         code_nibbles;
  logic [WIDTH_W-1:0] column;
  logic [LINES_W-1:0] lines_done;
  bit                 field_over;

  run_t expected_runs [$];

  function automatic logic [WIDTH_W-1:0] active_width();
    if (width_reg == '0) return WIDTH_W'(1);
    if (width_reg > MAX_WIDTH_VAL) return MAX_WIDTH_VAL;
    return width_reg;
  endfunction

  // Add one nibble to the code; return 1 with the run when a code completes
  function automatic bit decode_nibble(input logic [3:0] nib, output run_t run);
    logic [15:0]        code;
    logic [WIDTH_W-1:0] room;
    logic [WIDTH_W-1:0] w;
    logic [13:0]        len;
    bit                 whole;
    code = {code_bits, nib};
    w    = active_width();
    room = (column < w) ? (w - column) : WIDTH_W'(1);
    case (code_nibbles)
      2'd0:    whole = (code >= CODE_MIN_ONE);
      2'd1:    whole = (code >= CODE_MIN_TWO);
      2'd2:    whole = (code >= CODE_MIN_THREE);
      default: whole = 1'b1;
    endcase
    run = '0;
    if (!whole) begin
      code_bits    = code[11:0];
      code_nibbles = code_nibbles + 2'd1;
      return 1'b0;
    end
    code_bits    = '0;
    code_nibbles = '0;
    // Zero length fills the line; anything longer than the rest is clamped
    len = code[15:2];
    if (len == '0 || len > 14'(room)) len = 14'(room);
    run.run_color  = pixel_word[code[1:0] & COLOR_MASK];
    run.run_length = len[WIDTH_W-1:0];
    run.line_index = lines_done[LINE_IDX_W-1:0];
    if (len == 14'(room)) begin
      run.end_of_line = 1'b1;
      column          = '0;
      lines_done      = lines_done + LINES_W'(1);
      if (lines_done >= lines_reg) field_over = 1'b1;
    end else begin
      column = column + len[WIDTH_W-1:0];
    end
    return 1'b1;
  endfunction

  // Decode one byte, high nibble first, and queue the runs it yields
  function automatic void decode_byte(logic [7:0] data, logic start);
    run_t hi_run;
    run_t lo_run;
    bit   got_hi;
    bit   got_lo;
    if (start) begin
      code_bits    = '0;
      code_nibbles = '0;
      column       = '0;
      lines_done   = '0;
      field_over   = 1'b0;
    end
    if (field_over) return;
    got_hi = decode_nibble(data[7:4], hi_run);
    got_lo = 1'b0;
    // A line that ends on the high nibble drops the low one
    if (!(got_hi && hi_run.end_of_line)) got_lo = decode_nibble(data[3:0], lo_run);
    if (got_lo) begin
      lo_run.last = 1'b1;
      if (got_hi) expected_runs.push_back(hi_run);
      expected_runs.push_back(lo_run);
    end else if (got_hi) begin
      hi_run.last = 1'b1;
      expected_runs.push_back(hi_run);
    end
  endfunction

  always @(posedge clk) begin
    run_t got;
    run_t want;
    if (rst) begin
      width_reg    = RESET_WIDTH;
      lines_reg    = RESET_LINES;
      foreach (pixel_word[i]) pixel_word[i] = '0;
      code_bits    = '0;
      code_nibbles = '0;
      column       = '0;
      lines_done   = '0;
      field_over   = 1'b0;
      expected_runs.delete();
      failures     = 0;
      checked      = 0;
    end else begin
      // Apply register writes
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_LINE_WIDTH:  width_reg     = cfg.data[WIDTH_W-1:0];
          REG_FIELD_LINES: lines_reg     = cfg.data[LINES_W-1:0];
          REG_COLOR_ZERO:  pixel_word[0] = cfg.data;
          REG_COLOR_ONE:   pixel_word[1] = cfg.data;
          REG_COLOR_TWO:   pixel_word[2] = cfg.data;
          REG_COLOR_THREE: pixel_word[3] = cfg.data;
          default: ;
        endcase
      end
      // Predict runs of an accepted byte
      if (byte_in.valid && byte_in.ready) decode_byte(byte_in.data_byte, byte_in.field_start);
      // Compare an accepted run word with the oldest prediction
      if (run_out.valid && run_out.ready) begin
        got.run_color   = run_out.run_color;
        got.run_length  = run_out.run_length;
        got.end_of_line = run_out.end_of_line;
        got.line_index  = run_out.line_index;
        got.last        = run_out.last;
        if (expected_runs.size() == 0) begin
          failures++;
          if (failures <= REPORT_LIMIT)
            $display("unexpected run: color %h length %0d eol %0b line %0d last %0b",
                     got.run_color, got.run_length, got.end_of_line, got.line_index,
                     got.last);
        end else begin
          want = expected_runs.pop_front();
          checked++;
          if (got.run_color !== want.run_color || got.run_length !== want.run_length ||
              got.end_of_line !== want.end_of_line ||
              got.line_index !== want.line_index || got.last !== want.last) begin
            failures++;
            if (failures <= REPORT_LIMIT) begin
              $display("run %0d mismatch: expected color %h length %0d eol %0b line %0d last %0b",
                       checked, want.run_color, want.run_length, want.end_of_line,
                       want.line_index, want.last);
              $display("run %0d mismatch:      got color %h length %0d eol %0b line %0d last %0b",
                       checked, got.run_color, got.run_length, got.end_of_line,
                       got.line_index, got.last);
            end
          end
        end
      end
    end
    pending = expected_runs.size();
  end

endmodule

// ===== tb/dvd_subpicture_rle_decoder_unit_tb.sv =====
// ----------------------------------------------------------------------------
// dvd_subpicture_rle_decoder_unit_tb
// Drives encoded subpicture fields into the decoder under a series of line
// widths, line counts and pixel words, with random idle on both channels;
// the run checker beside the block predicts and compares every run.
// ----------------------------------------------------------------------------
module dvd_subpicture_rle_decoder_unit_tb import dspr_pkg::*;;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_BYTES = 1800;
  localparam int MAX_IDLE     = 12;
  localparam int DRAIN_CYCLES = 4;
  localparam int PHASES       = 12;

  typedef struct packed {
    logic       start;
    logic [7:0] data;
  } enc_byte_t;

  // Opening sequence: {field_start, byte}; width 16, three lines per field
  localparam logic [8:0] OPENING [22] = '{
    9'h145, 9'h012, 9'h004, 9'h07F, 9'h000, 9'h003, 9'h003, 9'h0FF,
    9'h0AB, 9'h0FF, 9'h100, 9'h03E, 9'h08C, 9'h0FF, 9'h000, 9'h000,
    9'h001, 9'h14F, 9'h000, 9'h000, 9'h0C1, 9'h010
  };

  // Settings per phase; includes zero, over-range and register maximums
  localparam int PHASE_WIDTH [PHASES] = '{720, 1, 0, 8191, 4096, 5, 64, 3, 33, 4097, 200, 2};
  localparam int PHASE_LINES [PHASES] = '{288, 1, 0, 2, 2048, 40, 12, 2048, 7, 1, 20, 4095};

  logic clk = 1'b0;
  logic rst = 1'b1;

  dspr_in_if  byte_ch ();
  dspr_out_if run_ch ();
  dspr_cfg_if cfg_ch ();

  int fail_count;
  int runs_pending;
  int runs_checked;
  int bytes_sent    = 0;
  int settings_used = 0;
  int cycles        = 0;
  bit sender_calm   = 1'b0;
  bit receiver_calm = 1'b0;

  logic [3:0] nibble_q [$];
  enc_byte_t  byte_q [$];

  dvd_subpicture_rle_decoder_unit dut (
    .clk     (clk),
    .rst     (rst),
    .byte_in (byte_ch),
    .run_out (run_ch),
    .cfg     (cfg_ch)
  );

  rle_run_checker checker_i (
    .clk      (clk),
    .rst      (rst),
    .byte_in  (byte_ch),
    .run_out  (run_ch),
    .cfg      (cfg_ch),
    .failures (fail_count),
    .pending  (runs_pending),
    .checked  (runs_checked)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d runs still expected", cycles, runs_pending);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Run sink: stall a random number of cycles, then take one word
  initial begin
    int stall;
    run_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = receiver_calm ? 0 : $urandom_range(0, MAX_IDLE);
      if (stall > 0) begin
        run_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      run_ch.ready <= 1'b1;
      do @(posedge clk); while (!run_ch.valid);
    end
  end

  // Append one run code, 1 to 4 nibbles depending on its length
  task automatic push_code(int run_len, logic [1:0] color);
    logic [15:0] code;
    int          count;
    code = 16'((run_len << 2) | color);
    if (run_len == 0 || run_len > 63) count = 4;
    else if (run_len > 15) count = 3;
    else if (run_len > 3) count = 2;
    else count = 1;
    for (int i = count - 1; i >= 0; i--) nibble_q.push_back(code[4*i +: 4]);
  endtask

  // Build lines of runs, mostly closed by a fill code, each padded to a byte
  task automatic queue_field(bit start, int line_total);
    enc_byte_t b;
    int        run_len;
    bit        first;
    nibble_q.delete();
    repeat (line_total) begin
      repeat ($urandom_range(0, 5)) begin
        case ($urandom_range(0, 3))
          0:       run_len = $urandom_range(1, 3);
          1:       run_len = $urandom_range(4, 15);
          2:       run_len = $urandom_range(16, 63);
          default: run_len = $urandom_range(64, 255);
        endcase
        push_code(run_len, 2'($urandom_range(0, 3)));
      end
      if ($urandom_range(0, 7) != 0) push_code(0, 2'($urandom_range(0, 3)));
      if (nibble_q.size() % 2 != 0) nibble_q.push_back(4'h0);
    end
    first = start;
    while (nibble_q.size() > 0) begin
      b.start     = first;
      b.data[7:4] = nibble_q.pop_front();
      b.data[3:0] = nibble_q.pop_front();
      byte_q.push_back(b);
      first = 1'b0;
    end
  endtask

  // Offer one byte after a random gap and hold it until taken
  task automatic send_byte(enc_byte_t b);
    int idle;
    idle = sender_calm ? 0 : $urandom_range(0, MAX_IDLE);
    if (idle > 0) begin
      byte_ch.valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    byte_ch.valid       <= 1'b1;
    byte_ch.data_byte   <= b.data;
    byte_ch.field_start <= b.start;
    do @(posedge clk); while (!byte_ch.ready);
    bytes_sent++;
  endtask

  task automatic flush_bytes();
    while (byte_q.size() > 0) send_byte(byte_q.pop_front());
  endtask

  // Drop valid and wait for every predicted run, then let the block drain
  task automatic settle();
    byte_ch.valid <= 1'b0;
    @(posedge clk);
    while (runs_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  function automatic logic [COLOR_W-1:0] pick_color();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // Write all six registers back to back
  task automatic configure(int width, int lines);
    write_reg(REG_LINE_WIDTH, CFG_DATA_W'(width));
    write_reg(REG_FIELD_LINES, CFG_DATA_W'(lines));
    write_reg(REG_COLOR_ZERO, pick_color());
    write_reg(REG_COLOR_ONE, pick_color());
    write_reg(REG_COLOR_TWO, pick_color());
    write_reg(REG_COLOR_THREE, pick_color());
    cfg_ch.valid <= 1'b0;
    settings_used++;
  endtask

  initial begin
    int phase_base;
    int budget;
    enc_byte_t b;
    byte_ch.valid       <= 1'b0;
    byte_ch.data_byte   <= '0;
    byte_ch.field_start <= 1'b0;
    cfg_ch.valid        <= 1'b0;
    cfg_ch.index        <= REG_LINE_WIDTH;
    cfg_ch.data         <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Opening: every code size, clamp, fill, high-nibble line end, done field
    configure(16, 3);
    foreach (OPENING[i]) byte_q.push_back(OPENING[i]);
    flush_bytes();
    settle();

    // Random phases; state may carry over so a new width can cut a line
    budget = RANDOM_BYTES / PHASES;
    for (int p = 0; p < PHASES; p++) begin
      configure(PHASE_WIDTH[p], PHASE_LINES[p]);
      sender_calm   = ($urandom_range(0, 3) == 0);
      receiver_calm = ($urandom_range(0, 3) == 0);
      phase_base    = bytes_sent;
      if ($urandom_range(0, 1) == 1) begin
        queue_field(1'b0, 1);
        flush_bytes();
      end
      while (bytes_sent - phase_base < budget) begin
        if ($urandom_range(0, 7) == 0) begin
          // Noise: raw bytes with stray field starts
          repeat ($urandom_range(1, 12)) begin
            b.data  = 8'($urandom);
            b.start = ($urandom_range(0, 15) == 0);
            byte_q.push_back(b);
          end
        end else begin
          queue_field(1'b1, $urandom_range(1, 6));
          // Trailing bytes, usually after the field has finished
          repeat ($urandom_range(0, 3)) begin
            b.data  = 8'($urandom);
            b.start = 1'b0;
            byte_q.push_back(b);
          end
        end
        flush_bytes();
      end
      settle();
    end

    $display("covered %0d encoded bytes under %0d register settings, %0d runs compared",
             bytes_sent, settings_used, runs_checked);
    if (fail_count == 0 && runs_pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
